// ===== rtl/assert_macros.svh =====
// assertion macros used by the blob extractor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CBE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define CBE_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define CBE_ASSERT_IMPL(label, clk, rst_n, prop)
`define CBE_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/cbe_pkg.sv =====
// shared constants and types of the blob extractor
package cbe_pkg;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(DEPTH);
    localparam int PW         = AW + 1;
    localparam int CW         = 7;
    localparam int BW         = 10;
    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // one result beat
    typedef struct packed {
        logic [BW-1:0] blob_number;
        logic [5:0]    point_x;
        logic [5:0]    point_y;
        logic          blob_last;
        logic          frame_done;
    } result_t;
endpackage

// ===== rtl/cbe_ram.sv =====
// generic single-port-write, one-read synchronous ram
module cbe_ram #(
    parameter int DW = 1,
    parameter int AWID = 12
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AWID-1:0] waddr,
    input  logic [DW-1:0]   wdata,
    input  logic [AWID-1:0] raddr,
    output logic [DW-1:0]   rdata
);
    logic [DW-1:0] mem [0:(1<<AWID)-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/connected_blob_extractor_core.sv =====
// connected blob extractor top level: sequencer around pixel, visited and queue rams
//
// Usage: cfg_we/cfg_index/cfg_data write frame_width (0) and frame_height (1)
// while idle. The input channel (in_valid/in_ready) carries command and
// pixel_value. A load beat (command 0) stores one raster pixel in its accept
// cycle and gives no result, so loads can follow at one per cycle while no
// result beat waits on out_ready. Once width*height pixels are loaded, each
// read beat (command 1) gives one result beat on out_valid/out_ready: a blob
// point with blob number and last-of-blob mark, or a frame_done beat when no
// blob remains. A point from the queue passes through the queue entry read,
// the index to column/row division, the neighbour reads and visited writes
// over the 3x3 neighbourhood, and the result register. When a new seed must
// be found, the scan first goes on in raster order to the next set pixel not
// yet visited; a frame_done beat follows a scan that reaches the frame end.
// After frame_done a clearing pass sweeps the whole visited ram before the
// next beat is taken; the same pass runs after reset. The result register
// holds its beat while the receiver stalls, and the next item is taken the
// cycle after the result beat has gone, once any clearing pass is over.
module connected_blob_extractor_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [7:0]            pixel_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [9:0]            blob_number,
    output logic [5:0]            point_x,
    output logic [5:0]            point_y,
    output logic                  blob_last,
    output logic                  frame_done
);
    import cbe_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SCANR = 10'b0000000100,
        S_SCANW = 10'b0000001000,
        S_QRD   = 10'b0000010000,
        S_QWAIT = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_NRD   = 10'b0010000000,
        S_NCHK  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] width_reg, height_reg;
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [PW-1:0] scan_reg, scan_next, load_reg, load_next;
    logic [BW-1:0] blob_reg, blob_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [6:0]    px_reg, px_next;
    logic [AW-1:0] py_reg, py_next;
    logic [1:0]    dr_reg, dr_next, dc_reg, dc_next;
    logic [3:0]    div_cnt_reg, div_cnt_next;
    logic [AW-1:0] naddr_reg, naddr_next;
    logic          nok_reg, nok_next;
    result_t       res_reg, res_next;
    logic          ov_reg, ov_next;

    // effective frame size
    logic [6:0] w_eff, h_eff;
    logic [PW-1:0] total;
    always_comb
    begin
        w_eff = (width_reg == '0) ? 7'd1 :
                (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? 7'd1 :
                (height_reg > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_reg;
        total = PW'(w_eff) * PW'(h_eff);
    end

    // rams
    logic          pix_we, vis_we, q_we;
    logic [AW-1:0] pix_wa, pix_ra, vis_wa, vis_ra, q_wa, q_ra;
    logic          pix_wd, vis_wd, pix_rd, vis_rd;
    logic [AW-1:0] q_rd;
    logic [AW-1:0] q_wd;

    cbe_ram #(.DW(1), .AWID(AW)) u_pix (.clk(clk), .we(pix_we), .waddr(pix_wa),
        .wdata(pix_wd), .raddr(pix_ra), .rdata(pix_rd));
    cbe_ram #(.DW(1), .AWID(AW)) u_vis (.clk(clk), .we(vis_we), .waddr(vis_wa),
        .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd));
    cbe_ram #(.DW(AW), .AWID(AW)) u_q (.clk(clk), .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    logic acc;
    assign acc = in_valid && in_ready;

    // one restoring division step: remainder in px_reg, dividend/quotient in py_reg
    logic [6:0] div_trial;
    logic       div_fit;
    always_comb
    begin
        div_trial = {px_reg[5:0], py_reg[AW-1]};
        div_fit = (div_trial >= w_eff);
    end

    // neighbour at row offset dr, column offset dc (both biased by one)
    logic [PW-1:0] nrow_p;
    logic [7:0]    ncol_p;
    logic [6:0]    nrow, ncol;
    logic [AW-1:0] nidx;
    logic          nvalid;
    always_comb
    begin
        nrow_p = PW'(py_reg) + PW'(dr_reg);
        ncol_p = 8'(px_reg) + 8'(dc_reg);
        nrow = 7'(nrow_p - PW'(1));
        ncol = 7'(ncol_p - 8'd1);
        nvalid = (nrow_p != '0) && ((nrow_p - PW'(1)) < PW'(h_eff)) &&
                 (ncol_p != '0) && ((ncol_p - 8'd1) < 8'(w_eff));
        nidx = AW'(nrow) * AW'(w_eff) + AW'(ncol);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg; tail_next = tail_reg; scan_next = scan_reg;
        load_next = load_reg; blob_next = blob_reg; clr_next = clr_reg;
        px_next = px_reg; py_next = py_reg; dr_next = dr_reg; dc_next = dc_reg;
        div_cnt_next = div_cnt_reg;
        naddr_next = naddr_reg; nok_next = nok_reg;
        res_next = res_reg; ov_next = ov_reg;
        pix_we = 1'b0; pix_wa = load_reg[AW-1:0]; pix_wd = (pixel_value != 8'd0);
        pix_ra = scan_reg[AW-1:0];
        vis_we = 1'b0; vis_wa = scan_reg[AW-1:0]; vis_wd = 1'b1;
        vis_ra = scan_reg[AW-1:0];
        q_we = 1'b0; q_wa = tail_reg[AW-1:0]; q_wd = scan_reg[AW-1:0];
        q_ra = head_reg[AW-1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                vis_we = 1'b1; vis_wa = clr_reg; vis_wd = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    if (command == CMD_LOAD)
                    begin
                        if (load_reg < total)
                        begin
                            pix_we = 1'b1;
                            load_next = load_reg + 1'b1;
                        end
                    end
                    else if (load_reg >= total)
                    begin
                        state_next = (head_reg >= tail_reg) ? S_SCANR : S_QRD;
                    end
                end
            end
            S_SCANR:
            begin
                if (scan_reg >= total)
                begin
                    res_next = '{blob_number: blob_reg, point_x: '0, point_y: '0,
                                 blob_last: 1'b0, frame_done: 1'b1};
                    ov_next = 1'b1;
                    head_next = '0; tail_next = '0; scan_next = '0;
                    load_next = '0; blob_next = '0; clr_next = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                vis_we = 1'b1;
                scan_next = scan_reg + 1'b1;
                pix_ra = scan_next[AW-1:0];
                vis_ra = scan_next[AW-1:0];
                state_next = S_SCANR;
                if (!vis_rd && pix_rd)
                begin
                    q_we = 1'b1; q_wa = '0;
                    head_next = '0; tail_next = PW'(1);
                    blob_next = blob_reg + 1'b1;
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                q_ra = head_reg[AW-1:0];
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                py_next = q_rd;
                px_next = '0;
                div_cnt_next = '0;
                head_next = head_reg + 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                px_next = div_fit ? (div_trial - w_eff) : div_trial;
                py_next = {py_reg[AW-2:0], div_fit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'(AW - 1))
                begin
                    dr_next = '0;
                    dc_next = '0;
                    state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                naddr_next = nidx;
                nok_next = nvalid;
                pix_ra = nidx;
                vis_ra = nidx;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (nok_reg && !vis_rd)
                begin
                    vis_we = 1'b1; vis_wa = naddr_reg;
                    if (pix_rd && tail_reg < PW'(DEPTH))
                    begin
                        q_we = 1'b1; q_wa = tail_reg[AW-1:0]; q_wd = naddr_reg;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (dc_reg == 2'd2)
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 1'b1;
                end
                else
                begin
                    dc_next = dc_reg + 1'b1;
                end
                state_next = (dr_reg == 2'd2 && dc_reg == 2'd2) ? S_OUT : S_NRD;
            end
            S_OUT:
            begin
                res_next = '{blob_number: blob_reg - 1'b1, point_x: px_reg[5:0],
                             point_y: py_reg[5:0], blob_last: head_reg >= tail_reg,
                             frame_done: 1'b0};
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            width_reg <= 7'd64; height_reg <= 7'd64;
            head_reg <= '0; tail_reg <= '0; scan_reg <= '0; load_reg <= '0;
            blob_reg <= '0; clr_reg <= '0; ov_reg <= 1'b0;
            dr_reg <= '0; dc_reg <= '0; div_cnt_reg <= '0; nok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next; tail_reg <= tail_next; scan_reg <= scan_next;
            load_reg <= load_next; blob_reg <= blob_next; clr_reg <= clr_next;
            ov_reg <= ov_next; dr_reg <= dr_next; dc_reg <= dc_next;
            div_cnt_reg <= div_cnt_next; nok_reg <= nok_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH) width_reg <= cfg_data;
                else height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next; py_reg <= py_next;
        naddr_reg <= naddr_next; res_reg <= res_next;
    end

    assign out_valid   = ov_reg;
    assign blob_number = res_reg.blob_number;
    assign point_x     = res_reg.point_x;
    assign point_y     = res_reg.point_y;
    assign blob_last   = res_reg.blob_last;
    assign frame_done  = res_reg.frame_done;

`include "assert_macros.svh"
    `CBE_NEVER(a_head_past_tail, clk, rst_n, (state_reg == S_OUT) && (head_reg > tail_reg))
    `CBE_NEVER(a_ready_while_busy, clk, rst_n, in_ready && ov_reg)
    `CBE_NEVER(a_tail_overflow, clk, rst_n, tail_reg > PW'(DEPTH))
    `CBE_ASSERT_IMPL(a_out_holds, clk, rst_n, (ov_reg && !out_ready) |=> ov_reg)
endmodule
